@@ rtl/sorted_priority_queue_core_defines.svh @@
// assertion macros shared by the sorted priority queue rtl
// no dependencies; assertions compile away when SYNTHESIS is defined
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, ignored while reset is asserted
`define SPQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spq assertion failed");
// checked property, also during reset
`define SPQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("spq assertion failed");
`else
`define SPQ_ASSERT(label, prop)
`define SPQ_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ rtl/spq_pkg.sv @@
// shared types and constants for the sorted priority queue
// no dependencies
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int PRIO_W      = 16;
  localparam int OUT_CNT_W   = 5;
  localparam int ERR_W       = 2;

  // request codes
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  // one stored entry
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
  } entry_t;

  // shift control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

@@ rtl/spq_cell.sv @@
// one slot of the sorted queue: holds an entry and compares it against a push
// depends on spq_pkg
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  spq_pkg::entry_t    new_entry,
  input  spq_pkg::entry_t    left_entry,
  input  logic               left_ins,
  input  spq_pkg::entry_t    right_entry,
  output logic               ins,
  output spq_pkg::entry_t    entry,
  output spq_pkg::entry_t    entry_nxt
);
  import spq_pkg::*;

  entry_t entry_r;

  // new entry lands here or ahead of here unless this slot holds a
  // smaller or equal priority
  assign ins = !(occupied && (entry_r.prio <= new_entry.prio));

  // next content: keep, take the new entry, shift right on push, shift left on pop
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.push && ins) begin
      entry_nxt = left_ins ? left_entry : new_entry;
    end else if (ctl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

@@ rtl/sorted_priority_queue_core.sv @@
// sorted priority queue: a row of compare-and-shift cells plus output register
// depends on spq_pkg, spq_cell and sorted_priority_queue_core_defines.svh
//
// Usage: every input request is a push (in_command = push, with in_item_value
// and in_item_priority) or a pop of the head entry. Each request yields exactly
// one result: the head entry after the operation (zero when empty), the empty
// flag, the entry count and an error code (push to a full queue and pop of an
// empty queue leave the contents unchanged and are flagged).
// The result is registered: it appears in the cycle after the request is accepted.
// Throughput: one request per cycle while in_stall is low; every cell compares its priority with the
// pushed one in the same cycle and shifts toward or away from the head,
// so the update never walks the row.
// Equal priorities leave in arrival order.
// Stall: the result waits in the output register while out_stall is high;
// in_stall is raised only while a held result is stalled, so a new request is
// taken in the same cycle the old result leaves.
// Reset (rst_n low, synchronous): the queue is empty and no result is pending.
// Cell contents are not cleared; only occupied cells are ever read.
`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic signed [spq_pkg::VALUE_W-1:0] in_item_value,
  input  logic [spq_pkg::PRIO_W-1:0]      in_item_priority,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [spq_pkg::VALUE_W-1:0] out_head_value,
  output logic [spq_pkg::PRIO_W-1:0]      out_head_priority,
  output logic                            out_is_empty,
  output logic [spq_pkg::OUT_CNT_W-1:0]   out_entry_count,
  output logic [spq_pkg::ERR_W-1:0]       out_error_code
);
  import spq_pkg::*;

  logic             accept;
  logic             is_pop;
  logic             full;
  logic             empty;
  cell_ctl_t        ctl;
  entry_t           new_entry;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [ERR_W-1:0] err;
  entry_t           cur   [QUEUE_DEPTH];
  entry_t           nxt   [QUEUE_DEPTH];
  logic             ins   [QUEUE_DEPTH];

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] head_value_r;
  logic [PRIO_W-1:0]         head_priority_r;
  logic                      is_empty_r;
  logic [OUT_CNT_W-1:0]      entry_count_r;
  logic [ERR_W-1:0]          error_code_r;

  // request handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_pop   = (in_command == CMD_POP);
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);

  assign new_entry.value = in_item_value;
  assign new_entry.prio  = in_item_priority;

  // shift control and error decode
  always_comb begin
    ctl.push  = 1'b0;
    ctl.pop   = 1'b0;
    err       = ERR_OK;
    count_nxt = count_r;
    if (accept) begin
      if (!is_pop) begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          ctl.push  = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (empty) begin
          err = ERR_EMPTY;
        end else begin
          ctl.pop   = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  // row of cells, head at index zero
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CNT_W'(i) < count_r),
      .new_entry   (new_entry),
      .left_entry  ((i == 0) ? new_entry : cur[(i == 0) ? 0 : i - 1]),
      .left_ins    ((i == 0) ? 1'b0 : ins[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == QUEUE_DEPTH - 1) ? cur[i] : cur[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .ins         (ins[i]),
      .entry       (cur[i]),
      .entry_nxt   (nxt[i])
    );
  end

  // fill count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (count_nxt == '0) begin
        head_value_r    <= '0;
        head_priority_r <= '0;
        is_empty_r      <= 1'b1;
      end else begin
        head_value_r    <= nxt[0].value;
        head_priority_r <= nxt[0].prio;
        is_empty_r      <= 1'b0;
      end
      entry_count_r <= OUT_CNT_W'(count_nxt);
      error_code_r  <= err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_head_value    = head_value_r;
  assign out_head_priority = head_priority_r;
  assign out_is_empty      = is_empty_r;
  assign out_entry_count   = entry_count_r;
  assign out_error_code    = error_code_r;

  // checks
  `SPQ_ASSERT(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH))
  `SPQ_ASSERT(a_sorted_head, (count_r >= CNT_W'(2)) |-> (cur[0].prio <= cur[1].prio))
  `SPQ_ASSERT(a_push_grows, (accept && !is_pop && !full) |=> (count_r == $past(count_r) + 1'b1))
  `SPQ_ASSERT(a_empty_flag, accept |=> (out_valid && (out_is_empty == (count_r == '0))))
  `SPQ_ASSERT(a_pop_empty_err, (accept && is_pop && empty) |=> (out_error_code == ERR_EMPTY))

endmodule
